[rtl/core/swa_pkg.sv]
// Shared types and constants for the sliding window aggregate block.
// No dependencies; imported by every module of the block.
package swa_pkg;
   localparam int WindowMaxDefault = 64;
   localparam int ValueBitsDefault = 32;
   localparam int SUM_BITS = 40;

   localparam logic [2:0] MODE_COUNT = 3'd0;
   localparam logic [2:0] MODE_SUM   = 3'd1;
   localparam logic [2:0] MODE_AVG   = 3'd2;
   localparam logic [2:0] MODE_MIN   = 3'd3;
   localparam logic [2:0] MODE_MAX   = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_DIVZERO = 2'd2;

   localparam logic [0:0] REG_MODE = 1'd0;
   localparam logic [0:0] REG_LEN  = 1'd1;

   typedef struct packed {
      logic        clear_first;
      logic        drop_oldest;
      logic        push_valid;
      logic [31:0] push_value;
      logic [15:0] push_pos;
      logic        emit;
      logic [15:0] window_start;
      logic [31:0] window_count;
   } req_type;

   typedef struct packed {
      logic [39:0] result_value;
      logic [1:0]  status;
   } rsp_type;
endpackage

[rtl/core/swa_divider.sv]
// Signed 40-bit by unsigned 32-bit restoring divider, one quotient bit a cycle.
// Depends on swa_pkg. Quotient truncates toward zero.
module swa_divider
   import swa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM_BITS-1:0] dividend,
   input  logic [31:0]         divisor,
   output logic                done,
   output logic [SUM_BITS-1:0] quotient
);
   logic [SUM_BITS-1:0] quo_ff, quo_in;
   logic [31:0]         rem_ff, rem_in;
   logic [31:0]         dvs_ff, dvs_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [SUM_BITS-1:0] mag;
   logic [32:0]         trial;

   assign mag   = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
   assign trial = {rem_ff, quo_ff[SUM_BITS-1]};

   // shift in one dividend bit, subtract when it fits
   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; neg_in = neg_ff; done_in = 1'b0;
      if (start) begin
         quo_in = mag; rem_in = '0; dvs_in = divisor;
         cnt_in = 6'(SUM_BITS); busy_in = 1'b1; neg_in = dividend[SUM_BITS-1];
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 32'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; dvs_ff <= dvs_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
endmodule

[rtl/core/sliding_window_aggregate.sv]
// Sliding window aggregate: count, sum, average, minimum and maximum.
// Depends on swa_pkg and swa_divider.
//
// Request beats arrive on req_valid/req_stall with a req_type payload;
// results leave on rsp_valid/rsp_stall as rsp_type, one per request with
// emit set. Mode and window length are written over the csr_ APB port
// (address 0 mode, 4 length); the user must write them only while the
// block is idle, which the block itself does not enforce. One request is
// in work at a time; req_stall is high meanwhile. A beat passes the drop,
// push and query states; without emit it returns to idle, and with emit
// count, sum and undefined modes go on to the output state. A deque push
// compares back entries while any remain, popping each dominated one
// through the back state, then writes; a minimum or maximum query adds a
// compare state and a front and compare state pair per entry pruned at
// the front, since a single comparator walks the deque memory. Average
// runs the one-bit-a-cycle divider. The result register holds a beat
// while rsp_stall is high; the next request is still taken and worked,
// and its finished beat waits for that register to be freed.
// Reset (synchronous) empties the sum, ring indices and deque, sets mode
// to sum and length to one. Memory contents are left as they are.
module sliding_window_aggregate
   import swa_pkg::*;
#(
   parameter int WINDOW_MAX = WindowMaxDefault,
   parameter int VALUE_BITS = ValueBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int VB = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int FW = $clog2(WINDOW_MAX + 1);

   localparam logic [3:0] S_IDLE = 4'd0, S_DROP = 4'd1, S_PUSH = 4'd2,
      S_BACK = 4'd3, S_BCMP = 4'd4, S_WRITE = 4'd5, S_QUERY = 4'd6,
      S_FRONT = 4'd7, S_FCMP = 4'd8, S_DIV = 4'd9, S_OUT = 4'd10;

   // configuration
   logic [2:0] mode_ff;
   logic [6:0] len_ff;
   logic       csr_wr;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[2])
         REG_MODE: csr_prdata = {29'd0, mode_ff};
         default:  csr_prdata = {25'd0, len_ff};
      endcase
   end

   // effective ring length minus one
   logic [IW-1:0] last_idx;
   always_comb begin
      priority if (len_ff == 7'd0) last_idx = '0;
      else if (32'(len_ff) > WINDOW_MAX) last_idx = IW'(WINDOW_MAX - 1);
      else last_idx = IW'(len_ff - 7'd1);
   end

   logic [3:0]          state_ff, state_in;
   req_type             req_ff;
   logic [IW-1:0]       head_ff, head_in, tail_ff, tail_in, front_ff, front_in;
   logic [FW-1:0]       fill_ff, fill_in;
   logic [SUM_BITS-1:0] sum_ff, sum_in;
   rsp_type             rsp_ff, rsp_in;
   rsp_type             acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [31:0]   ring_mem [WINDOW_MAX];
   logic [47:0]   dq_mem [WINDOW_MAX];
   logic [31:0]   ring_rd;
   logic [47:0]   dq_rd;
   logic [IW-1:0] ring_raddr, dq_raddr;
   logic          ring_we, dq_we;
   logic [IW-1:0] dq_waddr;

   logic signed [31:0] val;
   assign val = 32'(signed'(req_ff.push_value[VB-1:0]));

   logic ring_mode, dq_mode;
   assign ring_mode = mode_ff < MODE_MIN;
   assign dq_mode   = (mode_ff == MODE_MIN) || (mode_ff == MODE_MAX);

   function automatic logic [IW-1:0] wrap(input logic [IW-1:0] i, input logic [IW-1:0] l);
      wrap = (i >= l) ? '0 : IW'(i + 1'b1);
   endfunction

   function automatic logic [IW-1:0] modw(input logic [IW:0] i);
      modw = (32'(i) >= WINDOW_MAX) ? IW'(32'(i) - WINDOW_MAX) : i[IW-1:0];
   endfunction

   logic [IW-1:0] back_idx;
   assign back_idx = modw({1'b0, front_ff} + (IW+1)'(fill_ff) - 1'b1);

   // shared signed comparator, one deque entry at a time
   logic signed [31:0] cmp_a;
   logic dominated;
   assign cmp_a = signed'(dq_rd[31:0]);
   assign dominated = (mode_ff == MODE_MIN) ? (cmp_a >= val) : (cmp_a <= val);

   logic div_start, div_done;
   logic [SUM_BITS-1:0] quo;
   swa_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(sum_ff), .divisor(req_ff.window_count),
      .done(div_done), .quotient(quo)
   );

   logic accept;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // sequencer
   always_comb begin
      state_in = state_ff; head_in = head_ff; tail_in = tail_ff;
      front_in = front_ff; fill_in = fill_ff; sum_in = sum_ff;
      rsp_in = rsp_ff; rsp_valid_in = rsp_valid_ff; acc_in = acc_ff;
      ring_we = 1'b0; dq_we = 1'b0; dq_waddr = back_idx;
      ring_raddr = head_ff; dq_raddr = back_idx; div_start = 1'b0;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_DROP;
         S_DROP: begin
            // apply clear, then read the head entry
            if (req_ff.clear_first) begin
               head_in = '0; tail_in = '0; sum_in = '0; front_in = '0; fill_in = '0;
               ring_raddr = '0;
            end
            state_in = S_PUSH;
         end
         S_PUSH: begin
            if (req_ff.drop_oldest && ring_mode) begin
               sum_in  = sum_ff - SUM_BITS'(signed'(ring_rd));
               head_in = wrap(head_ff, last_idx);
            end
            state_in = S_QUERY;
            if (req_ff.push_valid && ring_mode) begin
               ring_we = 1'b1;
               tail_in = wrap(tail_ff, last_idx);
               sum_in  = sum_in + SUM_BITS'(val);
            end else if (req_ff.push_valid && dq_mode) begin
               state_in = (fill_ff != '0) ? S_BCMP : S_WRITE;
            end
         end
         S_BACK: state_in = (fill_ff != '0) ? S_BCMP : S_WRITE;
         S_BCMP: begin
            // pop dominated back entries
            if (dominated) begin
               fill_in = fill_ff - 1'b1; state_in = S_BACK;
            end else state_in = S_WRITE;
         end
         S_WRITE: begin
            dq_we = 1'b1;
            if (32'(fill_ff) >= WINDOW_MAX) begin
               front_in = modw({1'b0, front_ff} + 1'b1);
               dq_waddr = front_ff;
            end else begin
               dq_waddr = modw({1'b0, front_ff} + (IW+1)'(fill_ff));
               fill_in = fill_ff + 1'b1;
            end
            state_in = S_QUERY;
         end
         S_QUERY: begin
            state_in = S_OUT;
            acc_in.status = ST_OK; acc_in.result_value = '0;
            if (!req_ff.emit) state_in = S_IDLE;
            else if (mode_ff == MODE_COUNT)
               acc_in.result_value = SUM_BITS'(req_ff.window_count);
            else if (mode_ff == MODE_SUM) acc_in.result_value = sum_ff;
            else if (mode_ff == MODE_AVG) begin
               if (req_ff.window_count == '0) acc_in.status = ST_DIVZERO;
               else begin
                  div_start = 1'b1; state_in = S_DIV;
               end
            end else if (dq_mode) begin
               dq_raddr = front_ff; state_in = S_FCMP;
            end
         end
         S_FRONT: begin
            dq_raddr = front_ff; state_in = S_FCMP;
         end
         S_FCMP: begin
            // prune entries before the window start
            dq_raddr = front_ff;
            if (fill_ff == '0) begin
               acc_in.status = ST_EMPTY; state_in = S_OUT;
            end else if (dq_rd[47:32] < req_ff.window_start) begin
               front_in = modw({1'b0, front_ff} + 1'b1);
               fill_in = fill_ff - 1'b1; state_in = S_FRONT;
            end else begin
               acc_in.result_value = SUM_BITS'(cmp_a); state_in = S_OUT;
            end
         end
         S_DIV: if (div_done) begin
            acc_in.result_value = quo; state_in = S_OUT;
         end
         S_OUT: begin
            // hand the beat over once the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in = acc_ff; rsp_valid_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memories with registered reads
   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[tail_ff] <= val;
      if (dq_we) dq_mem[dq_waddr] <= {req_ff.push_pos, val};
      ring_rd <= ring_mem[ring_raddr];
      dq_rd   <= dq_mem[dq_raddr];
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      rsp_ff <= rsp_in;
      acc_ff <= acc_in;
      if (reset) begin
         state_ff <= S_IDLE; head_ff <= '0; tail_ff <= '0; front_ff <= '0;
         fill_ff <= '0; sum_ff <= '0; rsp_valid_ff <= 1'b0;
         mode_ff <= MODE_SUM; len_ff <= 7'd1;
      end else begin
         state_ff <= state_in; head_ff <= head_in; tail_ff <= tail_in;
         front_ff <= front_in; fill_ff <= fill_in; sum_ff <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr && csr_paddr == {REG_MODE, 2'b00}) mode_ff <= csr_pwdata[2:0];
         if (csr_wr && csr_paddr == {REG_LEN, 2'b00}) len_ff <= csr_pwdata[6:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

[rtl/core/swa_checker.sv]
// Port-level checks for sliding_window_aggregate, bound to the top level.
// Depends on swa_pkg.
module swa_checker
   import swa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);
   // one request in work at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("accept while busy");
   // status codes stay in range
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 2'd3) else $error("bad status");
   // stalled result holds
   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data)) else $error("rsp changed");
endmodule

bind sliding_window_aggregate swa_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
